// ===== hdl/square_integer_matrix_multiply_assert.svh =====
// Assertion macros shared by the matrix multiply RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef SQUARE_INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define SQUARE_INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIMM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/simm_pkg.sv =====
// Shared types and constants of the square integer matrix multiply.
// Depends on nothing; used by simm_mac, simm_ctrl and the top level.
package simm_pkg;

  localparam int IDX_W  = 4;
  localparam int DIM_W  = 5;
  localparam int DATA_W = 32;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_PRODUCT = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]              command;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [DATA_W-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_value;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
  } result_t;

  typedef struct packed {
    logic clear;
    logic term_valid;
  } mac_ctl_t;

endpackage

// ===== hdl/simm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module simm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/simm_mac.sv =====
// Shared multiply-accumulate unit: registered product, then wrapping sum.
// Depends on simm_pkg.
module simm_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  simm_pkg::mac_ctl_t            ctl,
  input  logic [simm_pkg::DATA_W-1:0]   a_data,
  input  logic [simm_pkg::DATA_W-1:0]   b_data,
  output logic [simm_pkg::DATA_W-1:0]   acc,
  output logic                          pipe_busy
);

  logic [simm_pkg::DATA_W-1:0] prod;
  logic                        mul_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= ctl.term_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
    if (ctl.clear) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + prod;
    end
  end

  assign pipe_busy = mul_v;

endmodule

// ===== hdl/simm_ctrl.sv =====
// Sequencer: dimension register, load decode, term counter, drain, result strobe.
// Depends on simm_pkg and square_integer_matrix_multiply_assert.svh.
`include "square_integer_matrix_multiply_assert.svh"

module simm_ctrl #(
  parameter int MAX_DIM = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  simm_pkg::item_t              item,
  input  logic                         matrix_dim_we,
  input  logic [simm_pkg::DIM_W-1:0]   matrix_dim_wdata,
  input  logic                         mac_busy,
  output logic                         busy,
  output logic                         done,
  output simm_pkg::mac_ctl_t           mac_ctl,
  output logic                         we_a,
  output logic                         we_b,
  output logic [2*$clog2(MAX_DIM)-1:0] waddr,
  output logic [2*$clog2(MAX_DIM)-1:0] raddr_a,
  output logic [2*$clog2(MAX_DIM)-1:0] raddr_b,
  output logic [simm_pkg::IDX_W-1:0]   out_row,
  output logic [simm_pkg::IDX_W-1:0]   out_col
);

  localparam int AW    = $clog2(MAX_DIM);
  localparam int CNT_W = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                     state, state_next;
  logic [simm_pkg::DIM_W-1:0] matrix_dim;
  logic [CNT_W-1:0]           eff_dim;
  logic [CNT_W-1:0]           k, k_next;
  logic [simm_pkg::IDX_W-1:0] row_q, col_q;
  logic                       rd_v;
  logic                       accept, in_store, req;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_dim <= simm_pkg::DIM_RESET;
    end else if (matrix_dim_we) begin
      matrix_dim <= matrix_dim_wdata;
    end
  end

  assign eff_dim = (int'(matrix_dim) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(matrix_dim);

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_store = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);
  assign req      = accept && (item.command == simm_pkg::CMD_PRODUCT);

  assign we_a  = accept && in_store && (item.command == simm_pkg::CMD_LOAD_A);
  assign we_b  = accept && in_store && (item.command == simm_pkg::CMD_LOAD_B);
  assign waddr = {AW'(item.row_index), AW'(item.col_index)};

  assign raddr_a = {AW'(row_q), k[AW-1:0]};
  assign raddr_b = {k[AW-1:0], AW'(col_q)};

  assign mac_ctl.clear      = req;
  assign mac_ctl.term_valid = rd_v;

  always_comb begin
    state_next = state;
    k_next     = k;
    case (state)
      S_IDLE: begin
        k_next = '0;
        if (req) begin
          if (in_store && (eff_dim != '0)) begin
            state_next = S_RUN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RUN: begin
        k_next = k + 1'b1;
        if (k_next == eff_dim) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v && !mac_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_v  <= 1'b0;
      k     <= '0;
    end else begin
      state <= state_next;
      rd_v  <= (state == S_RUN);
      k     <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      row_q <= item.row_index;
      col_q <= item.col_index;
    end
  end

  assign done    = (state == S_DONE);
  assign out_row = row_q;
  assign out_col = col_q;

  `SIMM_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held over two cycles")
  `SIMM_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "result strobe while idle")
  `SIMM_ASSERT_NEXT(a_req_busy, clk, rst, req, busy, "product transfer did not raise busy")
  `SIMM_ASSERT_NOW(a_term_state, clk, rst, rd_v, (state == S_DRAIN) || (state == S_RUN),
                   "term valid outside compute")

endmodule

// ===== hdl/square_integer_matrix_multiply.sv =====
// Square signed integer matrix multiply, top level.
// Depends on simm_pkg, simm_ram, simm_mac and simm_ctrl.
//
// Usage:
//   Input channel: an item transfers on a rising edge with start high and
//   busy low. Command 0 loads an element of A, command 1 of B; the next item
//   may follow at once. Command 3 is dropped.
//   Command 2 requests product element (row, col): busy rises and one shared
//   multiply-accumulate walks the effective dimension, one term per cycle,
//   reading A and B from two RAMs with registered read.
//   A request walks dim terms, then drains the MAC before the result (dim =
//   matrix_dim clipped to MAX_DIM); out-of-range coordinates or dim 0 skip to it.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall, so no storage sits behind it.
//   Configuration: the user must write matrix_dim (matrix_dim_we) only while the
//   block is idle; the block does not enforce it. Reset: synchronous rst returns
//   to idle, sets matrix_dim to 16; matrix contents are undefined until loaded.
module square_integer_matrix_multiply #(
  parameter int MAX_DIM = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  simm_pkg::item_t            item,
  output logic                       done,
  output simm_pkg::result_t          result,
  input  logic                       matrix_dim_we,
  input  logic [simm_pkg::DIM_W-1:0] matrix_dim_wdata
);

  localparam int AW    = $clog2(MAX_DIM);
  localparam int DEPTH = 1 << (2 * AW);

  logic                        we_a, we_b, mac_busy;
  logic [2*AW-1:0]             waddr, raddr_a, raddr_b;
  logic [simm_pkg::DATA_W-1:0] a_data, b_data, acc;
  logic [simm_pkg::IDX_W-1:0]  out_row, out_col;
  simm_pkg::mac_ctl_t          mac_ctl;

  simm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .item             (item),
    .matrix_dim_we    (matrix_dim_we),
    .matrix_dim_wdata (matrix_dim_wdata),
    .mac_busy         (mac_busy),
    .busy             (busy),
    .done             (done),
    .mac_ctl          (mac_ctl),
    .we_a             (we_a),
    .we_b             (we_b),
    .waddr            (waddr),
    .raddr_a          (raddr_a),
    .raddr_b          (raddr_b),
    .out_row          (out_row),
    .out_col          (out_col)
  );

  simm_ram #(.WIDTH(simm_pkg::DATA_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (item.element_value),
    .raddr (raddr_a),
    .rdata (a_data)
  );

  simm_ram #(.WIDTH(simm_pkg::DATA_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (item.element_value),
    .raddr (raddr_b),
    .rdata (b_data)
  );

  simm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .a_data    (a_data),
    .b_data    (b_data),
    .acc       (acc),
    .pipe_busy (mac_busy)
  );

  assign result.product_value = acc;
  assign result.out_row       = out_row;
  assign result.out_col       = out_col;

endmodule
